@@ hw/rtl/state_vector_gate_engine_macros.svh @@
// ----------------------------------------------------------------------------
// State vector gate engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STATE_VECTOR_GATE_ENGINE_MACROS_SVH
`define STATE_VECTOR_GATE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVGE_ASSERT_NOW(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVGE_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ hw/rtl/svge_pkg.sv @@
// ----------------------------------------------------------------------------
// State vector gate engine package
// Widths, fixed-point types, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package svge_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int AMP_BITS   = 18;
    localparam int FRAC_BITS  = AMP_BITS - 2;
    localparam int ADDR_W     = MAX_QUBITS;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int QUBIT_W    = 4;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = 2 * AMP_BITS;
    localparam int RND_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = RND_W + 2;

    typedef logic signed [AMP_BITS-1:0] amp_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [QUBIT_W-1:0]         qubit_t;
    typedef logic [FUNC_W-1:0]          func_t;
    typedef logic [STATUS_W-1:0]        status_t;

    typedef struct packed {
        amp_t re;
        amp_t im;
    } cplx_t;

    typedef struct packed {
        cplx_t m00;
        cplx_t m01;
        cplx_t m10;
        cplx_t m11;
    } mat_t;

    localparam amp_t AMP_ONE = amp_t'(2 ** FRAC_BITS);

    localparam func_t FN_BASIS = 3'd0;
    localparam func_t FN_GATE  = 3'd1;
    localparam func_t FN_CGATE = 3'd2;
    localparam func_t FN_SWAP  = 3'd3;
    localparam func_t FN_CSWAP = 3'd4;
    localparam func_t FN_READ  = 3'd5;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_QUBIT   = 2'd1;
    localparam status_t ST_INDEX   = 2'd2;
    localparam status_t ST_CTL_EQ  = 2'd3;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD_ADDR,
        S_RD_DATA,
        S_P_RD,
        S_Q_RD,
        S_A1,
        S_MUL,
        S_ACC,
        S_WR_P,
        S_WR_Q,
        S_NEXT,
        S_DONE
    } seq_state_t;

endpackage

@@ hw/rtl/state_vector_gate_engine.sv @@
// ----------------------------------------------------------------------------
// State vector gate engine
// Complex amplitude store with a read-modify-write sequencer for basis loads,
// 2x2 matrix gates, swaps and amplitude reads.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction
//  cfg       cfg_valid cfg_ready qubits_in_use  write, one register
//  in        in_valid in_ready func .. m11_im   command transaction
//  out       out_valid out_ready amp_re amp_im status  result transaction
//
//  One command is taken at a time through a single-read, single-write memory.
//  A read fetches one entry; errors skip to the result. Basis load clears
//  one entry per cycle. A matrix gate reads, multiplies and writes each pair;
//  a swap writes each pair back exchanged; of 2^(n-1) pairs, a pair whose
//  control bit is zero is skipped. After reset clearing runs with in_ready low.
//  The next command is taken while a result waits on a stalled out channel.
// ----------------------------------------------------------------------------
module state_vector_gate_engine
    import svge_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  qubit_t         qubits_in_use,
    input  logic           in_valid,
    output logic           in_ready,
    input  func_t          func,
    input  qubit_t         target_qubit,
    input  qubit_t         control_qubit,
    input  addr_t          basis_index,
    input  amp_t           m00_re,
    input  amp_t           m00_im,
    input  amp_t           m01_re,
    input  amp_t           m01_im,
    input  amp_t           m10_re,
    input  amp_t           m10_im,
    input  amp_t           m11_re,
    input  amp_t           m11_im,
    output logic           out_valid,
    input  logic           out_ready,
    output amp_t           amp_re,
    output amp_t           amp_im,
    output status_t        status
);

    seq_state_t state_reg, state_next;
    qubit_t     nq_reg, nq_next;
    logic       boot_reg, boot_next;
    addr_t      cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    func_t      func_reg, func_next;
    qubit_t     tq_reg, tq_next;
    qubit_t     cq_reg, cq_next;
    addr_t      basis_reg, basis_next;
    mat_t       mat_reg, mat_next;
    status_t    stat_reg, stat_next;
    cplx_t      a0_reg, a0_next;
    cplx_t      a1_reg, a1_next;
    amp_t       new_reg [4];
    logic       out_valid_reg, out_valid_next;
    amp_t       amp_re_reg, amp_re_next;
    amp_t       amp_im_reg, amp_im_next;
    status_t    status_reg, status_next;

    logic       accept;
    logic       ctl_in;
    status_t    in_stat;
    addr_t      low_mask;
    addr_t      p_addr;
    addr_t      q_addr;
    addr_t      pair_last;
    logic       ctl_cmd;
    logic       swap_cmd;
    logic       ctl_bit;
    logic       we;
    addr_t      waddr;
    cplx_t      wdata;
    addr_t      raddr;
    cplx_t      rdata;
    amp_t       alu_result;
    logic       load_out;

    svge_amp_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    svge_pair_alu u_alu (
        .clk    (clk),
        .phase  (phase_reg),
        .a0     (a0_reg),
        .a1     (a1_reg),
        .mat    (mat_reg),
        .result (alu_result)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign amp_re    = amp_re_reg;
    assign amp_im    = amp_im_reg;
    assign status    = status_reg;

    always_comb
    begin
        ctl_in = (func == FN_CGATE) || (func == FN_CSWAP);
        in_stat = ST_OK;
        if ((func == FN_BASIS) || (func == FN_READ))
        begin
            if ((basis_index >> nq_reg) != addr_t'(0))
            begin
                in_stat = ST_INDEX;
            end
        end
        else if ((func == FN_GATE) || (func == FN_CGATE) || (func == FN_SWAP)
                 || (func == FN_CSWAP))
        begin
            if ((target_qubit >= nq_reg) || (ctl_in && (control_qubit >= nq_reg)))
            begin
                in_stat = ST_QUBIT;
            end
            else if (ctl_in && (control_qubit == target_qubit))
            begin
                in_stat = ST_CTL_EQ;
            end
        end
    end

    always_comb
    begin
        low_mask  = (addr_t'(1) << tq_reg) - addr_t'(1);
        p_addr    = ((cnt_reg & ~low_mask) << 1) | (cnt_reg & low_mask);
        q_addr    = p_addr | (addr_t'(1) << tq_reg);
        pair_last = (addr_t'(1) << (nq_reg - qubit_t'(1))) - addr_t'(1);
        ctl_cmd   = (func_reg == FN_CGATE) || (func_reg == FN_CSWAP);
        swap_cmd  = (func_reg == FN_SWAP) || (func_reg == FN_CSWAP);
        ctl_bit   = |((p_addr >> cq_reg) & addr_t'(1));
    end

    always_comb
    begin
        state_next     = state_reg;
        nq_next        = nq_reg;
        boot_next      = boot_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        func_next      = func_reg;
        tq_next        = tq_reg;
        cq_next        = cq_reg;
        basis_next     = basis_reg;
        mat_next       = mat_reg;
        stat_next      = stat_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;
        out_valid_next = out_valid_reg;
        amp_re_next    = amp_re_reg;
        amp_im_next    = amp_im_reg;
        status_next    = status_reg;
        we             = 1'b0;
        waddr          = p_addr;
        wdata          = a0_reg;
        raddr          = p_addr;
        load_out       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (qubits_in_use == qubit_t'(0))
            begin
                nq_next = qubit_t'(1);
            end
            else if (qubits_in_use > qubit_t'(MAX_QUBITS))
            begin
                nq_next = qubit_t'(MAX_QUBITS);
            end
            else
            begin
                nq_next = qubits_in_use;
            end
        end

        case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = (cnt_reg == basis_reg) ? cplx_t'{re: AMP_ONE, im: '0} : '0;
                cnt_next = cnt_reg + addr_t'(1);
                if (cnt_reg == addr_t'(DEPTH - 1))
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    tq_next    = target_qubit;
                    cq_next    = control_qubit;
                    basis_next = basis_index;
                    mat_next   = '{m00: '{re: m00_re, im: m00_im},
                                   m01: '{re: m01_re, im: m01_im},
                                   m10: '{re: m10_re, im: m10_im},
                                   m11: '{re: m11_re, im: m11_im}};
                    stat_next  = in_stat;
                    cnt_next   = '0;
                    if (in_stat != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (func)
                            FN_BASIS: state_next = S_CLR;
                            FN_READ:  state_next = S_RD_ADDR;
                            FN_GATE, FN_CGATE, FN_SWAP, FN_CSWAP:
                                      state_next = S_P_RD;
                            default:  state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_RD_ADDR:
            begin
                raddr      = basis_reg;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                a0_next    = rdata;
                state_next = S_DONE;
            end
            S_P_RD:
            begin
                raddr = p_addr;
                if (ctl_cmd && !ctl_bit)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                raddr      = q_addr;
                a0_next    = rdata;
                state_next = S_A1;
            end
            S_A1:
            begin
                a1_next    = rdata;
                phase_next = '0;
                state_next = swap_cmd ? S_WR_P : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                phase_next = phase_reg + 2'd1;
                state_next = (phase_reg == 2'd3) ? S_WR_P : S_MUL;
            end
            S_WR_P:
            begin
                we         = 1'b1;
                waddr      = p_addr;
                wdata      = swap_cmd ? a1_reg : cplx_t'{re: new_reg[0], im: new_reg[1]};
                state_next = S_WR_Q;
            end
            S_WR_Q:
            begin
                we         = 1'b1;
                waddr      = q_addr;
                wdata      = swap_cmd ? a0_reg : cplx_t'{re: new_reg[2], im: new_reg[3]};
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                cnt_next = cnt_reg + addr_t'(1);
                if (cnt_reg == pair_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = stat_reg;
                    if ((func_reg == FN_READ) && (stat_reg == ST_OK))
                    begin
                        amp_re_next = a0_reg.re;
                        amp_im_next = a0_reg.im;
                    end
                    else
                    begin
                        amp_re_next = '0;
                        amp_im_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            nq_reg        <= qubit_t'(MAX_QUBITS);
            boot_reg      <= 1'b1;
            cnt_reg       <= '0;
            basis_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nq_reg        <= nq_next;
            boot_reg      <= boot_next;
            cnt_reg       <= cnt_next;
            basis_reg     <= basis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        func_reg  <= func_next;
        tq_reg    <= tq_next;
        cq_reg    <= cq_next;
        mat_reg   <= mat_next;
        stat_reg  <= stat_next;
        a0_reg    <= a0_next;
        a1_reg    <= a1_next;
        if (state_reg == S_ACC)
        begin
            new_reg[phase_reg] <= alu_result;
        end
        if (load_out)
        begin
            amp_re_reg <= amp_re_next;
            amp_im_reg <= amp_im_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ hw/rtl/svge_amp_ram.sv @@
// ----------------------------------------------------------------------------
// Amplitude memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module svge_amp_ram
    import svge_pkg::*;
(
    input  logic  clk,
    input  logic  we,
    input  addr_t waddr,
    input  cplx_t wdata,
    input  addr_t raddr,
    output cplx_t rdata
);

    cplx_t mem [DEPTH];
    cplx_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/svge_pair_alu.sv @@
// ----------------------------------------------------------------------------
// Pair arithmetic unit
// Four rounded products per phase, registered, then summed and saturated.
// ----------------------------------------------------------------------------
module svge_pair_alu
    import svge_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] phase,
    input  cplx_t      a0,
    input  cplx_t      a1,
    input  mat_t       mat,
    output amp_t       result
);

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'(2 ** (AMP_BITS - 1) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SAT_MAX - SUM_W'(1);

    cplx_t ma;
    cplx_t mb;
    amp_t  op_m [4];
    amp_t  op_a [4];
    logic signed [PROD_W-1:0] prod [4];
    logic signed [RND_W-1:0]  rnd_reg [4];
    logic                     odd_reg;
    logic signed [SUM_W-1:0]  sum;

    always_comb
    begin
        ma = phase[1] ? mat.m10 : mat.m00;
        mb = phase[1] ? mat.m11 : mat.m01;
        op_m[0] = ma.re;
        op_m[1] = ma.im;
        op_m[2] = mb.re;
        op_m[3] = mb.im;
        if (phase[0])
        begin
            op_a[0] = a0.im;
            op_a[1] = a0.re;
            op_a[2] = a1.im;
            op_a[3] = a1.re;
        end
        else
        begin
            op_a[0] = a0.re;
            op_a[1] = a0.im;
            op_a[2] = a1.re;
            op_a[3] = a1.im;
        end
        for (int i = 0; i < 4; i++)
        begin
            prod[i] = (PROD_W'(op_m[i]) * PROD_W'(op_a[i])) + RND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd_reg[i] <= prod[i][PROD_W-1:FRAC_BITS];
        end
        odd_reg <= phase[0];
    end

    always_comb
    begin
        if (odd_reg)
        begin
            sum = SUM_W'(rnd_reg[0]) + SUM_W'(rnd_reg[1])
                + SUM_W'(rnd_reg[2]) + SUM_W'(rnd_reg[3]);
        end
        else
        begin
            sum = SUM_W'(rnd_reg[0]) - SUM_W'(rnd_reg[1])
                + SUM_W'(rnd_reg[2]) - SUM_W'(rnd_reg[3]);
        end
        if (sum > SAT_MAX)
        begin
            result = amp_t'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            result = amp_t'(SAT_MIN);
        end
        else
        begin
            result = sum[AMP_BITS-1:0];
        end
    end

endmodule

@@ hw/rtl/svge_checker.sv @@
// ----------------------------------------------------------------------------
// State vector gate engine port checker
// Watches the top-level ports for result and command sequencing rules.
// ----------------------------------------------------------------------------
`include "state_vector_gate_engine_macros.svh"

module svge_checker
    import svge_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input amp_t    amp_re,
    input amp_t    amp_im,
    input status_t status
);

    // A failing command never carries an amplitude.
    `SVGE_ASSERT_NOW(a_err_zero, out_valid && (status != ST_OK), (amp_re == '0) && (amp_im == '0), "error result carries a nonzero amplitude")
    // Only one command is in flight, so ready drops after each accepted transaction.
    `SVGE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a command transaction")
    // A stalled result stays valid.
    `SVGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result was dropped")
    // A stalled result keeps its status.
    `SVGE_ASSERT_NEXT(a_status_hold, out_valid && !out_ready, $stable(status), "stalled result status changed")

endmodule

bind state_vector_gate_engine svge_checker u_svge_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// State vector gate engine testbench
// Drives basis loads, matrix gates, swaps, reads and bad commands through the
// command channel at several qubit counts, predicts every amplitude update in
// fixed point, and checks each result transaction against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import svge_pkg::*;

    typedef struct {
        func_t  fn;
        qubit_t tq;
        qubit_t cq;
        addr_t  idx;
        amp_t   m[8];
    } gate_cmd_t;

    typedef struct {
        amp_t    re;
        amp_t    im;
        status_t st;
    } gate_result_t;

    localparam func_t FN_NOP6 = 3'd6;
    localparam func_t FN_NOP7 = 3'd7;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    qubit_t  cfg_qubits = '0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    func_t   func = '0;
    qubit_t  target_qubit = '0;
    qubit_t  control_qubit = '0;
    addr_t   basis_index = '0;
    amp_t    m00_re = '0, m00_im = '0, m01_re = '0, m01_im = '0;
    amp_t    m10_re = '0, m10_im = '0, m11_re = '0, m11_im = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    amp_t    amp_re;
    amp_t    amp_im;
    status_t status;

    gate_cmd_t    pending_cmds[$];
    gate_result_t expected_results[$];
    gate_cmd_t    cmd_on_bus;
    amp_t         sv_re[DEPTH];
    amp_t         sv_im[DEPTH];
    int           model_qubits;
    int           send_idle;
    int           recv_idle;
    bit           tail_quiet = 1'b0;
    int           error_count = 0;

    state_vector_gate_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .qubits_in_use (cfg_qubits),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .target_qubit  (target_qubit),
        .control_qubit (control_qubit),
        .basis_index   (basis_index),
        .m00_re        (m00_re),
        .m00_im        (m00_im),
        .m01_re        (m01_re),
        .m01_im        (m01_im),
        .m10_re        (m10_re),
        .m10_im        (m10_im),
        .m11_re        (m11_re),
        .m11_im        (m11_im),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .amp_re        (amp_re),
        .amp_im        (amp_im),
        .status        (status)
    );

    always #5 clk = ~clk;

    function automatic longint round_mul(longint a, longint b);
        return (a * b + 64'sd32768) >>> FRAC_BITS;
    endfunction

    function automatic amp_t saturate(longint v);
        if (v > 131071)
        begin
            return amp_t'(131071);
        end
        if (v < -131072)
        begin
            return amp_t'(-131072);
        end
        return amp_t'(v);
    endfunction

    function automatic void clear_vector(int basis);
        for (int k = 0; k < DEPTH; k++)
        begin
            sv_re[k] = '0;
            sv_im[k] = '0;
        end
        sv_re[basis] = AMP_ONE;
    endfunction

    function automatic int clamp_qubits(int v);
        if (v < 1)
        begin
            return 1;
        end
        if (v > MAX_QUBITS)
        begin
            return MAX_QUBITS;
        end
        return v;
    endfunction

    function automatic gate_result_t predict_gate(gate_cmd_t c);
        gate_result_t r;
        int           len;
        int           tb;
        int           cb;
        bit           ctl;
        longint       m[8];
        longint       r0, i0, r1, i1;
        amp_t         tr, ti;
        len = 1 << model_qubits;
        ctl = (c.fn == FN_CGATE) || (c.fn == FN_CSWAP);
        r.re = '0;
        r.im = '0;
        r.st = ST_OK;
        for (int k = 0; k < 8; k++)
        begin
            m[k] = longint'(c.m[k]);
        end
        if (c.fn == FN_BASIS || c.fn == FN_READ)
        begin
            if (int'(c.idx) >= len)
            begin
                r.st = ST_INDEX;
            end
            else if (c.fn == FN_BASIS)
            begin
                clear_vector(c.idx);
            end
            else
            begin
                r.re = sv_re[c.idx];
                r.im = sv_im[c.idx];
            end
        end
        else if (c.fn >= FN_GATE && c.fn <= FN_CSWAP)
        begin
            if (int'(c.tq) >= model_qubits || (ctl && int'(c.cq) >= model_qubits))
            begin
                r.st = ST_QUBIT;
            end
            else if (ctl && c.cq == c.tq)
            begin
                r.st = ST_CTL_EQ;
            end
            else
            begin
                tb = 1 << c.tq;
                cb = ctl ? (1 << c.cq) : 0;
                for (int j = 0; j < len; j++)
                begin
                    if ((j & tb) != 0 || (j & cb) != cb)
                    begin
                        continue;
                    end
                    if (c.fn == FN_GATE || c.fn == FN_CGATE)
                    begin
                        r0 = sv_re[j];
                        i0 = sv_im[j];
                        r1 = sv_re[j | tb];
                        i1 = sv_im[j | tb];
                        sv_re[j] = saturate(round_mul(m[0], r0) - round_mul(m[1], i0)
                            + round_mul(m[2], r1) - round_mul(m[3], i1));
                        sv_im[j] = saturate(round_mul(m[0], i0) + round_mul(m[1], r0)
                            + round_mul(m[2], i1) + round_mul(m[3], r1));
                        sv_re[j | tb] = saturate(round_mul(m[4], r0) - round_mul(m[5], i0)
                            + round_mul(m[6], r1) - round_mul(m[7], i1));
                        sv_im[j | tb] = saturate(round_mul(m[4], i0) + round_mul(m[5], r0)
                            + round_mul(m[6], i1) + round_mul(m[7], r1));
                    end
                    else
                    begin
                        tr = sv_re[j];
                        ti = sv_im[j];
                        sv_re[j] = sv_re[j | tb];
                        sv_im[j] = sv_im[j | tb];
                        sv_re[j | tb] = tr;
                        sv_im[j | tb] = ti;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_gate(cmd_on_bus));
                next_valid = 1'b0;
                if (!tail_quiet && $urandom_range(0, 7) == 0)
                begin
                    send_idle = $urandom_range(1, 13);
                end
            end
            if (!next_valid)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    func          <= cmd_on_bus.fn;
                    target_qubit  <= cmd_on_bus.tq;
                    control_qubit <= cmd_on_bus.cq;
                    basis_index   <= cmd_on_bus.idx;
                    m00_re <= cmd_on_bus.m[0];
                    m00_im <= cmd_on_bus.m[1];
                    m01_re <= cmd_on_bus.m[2];
                    m01_im <= cmd_on_bus.m[3];
                    m10_re <= cmd_on_bus.m[4];
                    m10_im <= cmd_on_bus.m[5];
                    m11_re <= cmd_on_bus.m[6];
                    m11_im <= cmd_on_bus.m[7];
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        gate_result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_idle = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Unexpected result transaction: amp_re %0d amp_im %0d status %0d",
                        amp_re, amp_im, status);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (amp_re !== e.re)
                    begin
                        $error("amp_re mismatch: expected %0d, actual %0d", e.re, amp_re);
                        error_count++;
                    end
                    if (amp_im !== e.im)
                    begin
                        $error("amp_im mismatch: expected %0d, actual %0d", e.im, amp_im);
                        error_count++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", e.st, status);
                        error_count++;
                    end
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle--;
                out_ready <= 1'b0;
            end
            else if (!tail_quiet && $urandom_range(0, 9) == 0)
            begin
                recv_idle = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic amp_t random_entry();
        if ($urandom_range(0, 3) == 0)
        begin
            return amp_t'($urandom_range(0, 262143));
        end
        return amp_t'(int'($urandom_range(0, 140000)) - 70000);
    endfunction

    function automatic gate_cmd_t make_cmd(func_t fn, int tq, int cq, int idx, amp_t fill);
        gate_cmd_t c;
        c.fn = fn;
        c.tq = qubit_t'(tq);
        c.cq = qubit_t'(cq);
        c.idx = addr_t'(idx);
        for (int k = 0; k < 8; k++)
        begin
            c.m[k] = fill;
        end
        return c;
    endfunction

    function automatic gate_cmd_t random_cmd(int n);
        gate_cmd_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            c.fn = FN_BASIS;
        end
        else if (pick < 38)
        begin
            c.fn = FN_GATE;
        end
        else if (pick < 56)
        begin
            c.fn = FN_CGATE;
        end
        else if (pick < 66)
        begin
            c.fn = FN_SWAP;
        end
        else if (pick < 76)
        begin
            c.fn = FN_CSWAP;
        end
        else if (pick < 97)
        begin
            c.fn = FN_READ;
        end
        else
        begin
            c.fn = func_t'($urandom_range(6, 7));
        end
        c.tq = ($urandom_range(0, 9) == 0) ? qubit_t'($urandom_range(0, 15))
                                           : qubit_t'($urandom_range(0, n - 1));
        c.cq = ($urandom_range(0, 9) == 0) ? qubit_t'($urandom_range(0, 15))
                                           : qubit_t'($urandom_range(0, n - 1));
        c.idx = ($urandom_range(0, 9) == 0) ? addr_t'($urandom_range(0, 1023))
                                            : addr_t'($urandom_range(0, (1 << n) - 1));
        for (int k = 0; k < 8; k++)
        begin
            c.m[k] = random_entry();
        end
        return c;
    endfunction

    // Checked at the falling edge, when the driver's updates have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_qubits(int v);
        wait_idle();
        cfg_valid  <= 1'b1;
        cfg_qubits <= qubit_t'(v);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        model_qubits = clamp_qubits(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n_items);
        for (int k = 0; k < n_items; k++)
        begin
            pending_cmds.push_back(random_cmd(model_qubits));
        end
    endtask

    initial
    begin
        gate_cmd_t c;
        clear_vector(0);
        model_qubits = MAX_QUBITS;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 1023, '0));
        pending_cmds.push_back(make_cmd(FN_NOP6, 15, 15, 1023, amp_t'(-131072)));
        pending_cmds.push_back(make_cmd(FN_NOP7, 0, 0, 0, amp_t'(131071)));
        pending_cmds.push_back(make_cmd(FN_GATE, 10, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_CGATE, 3, 3, 0, '0));
        pending_cmds.push_back(make_cmd(FN_CSWAP, 2, 15, 0, '0));
        pending_cmds.push_back(make_cmd(FN_SWAP, 9, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 512, '0));

        write_qubits(0);
        pending_cmds.push_back(make_cmd(FN_BASIS, 0, 0, 2, '0));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 512, '0));
        pending_cmds.push_back(make_cmd(FN_GATE, 0, 0, 0, amp_t'(131071)));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_GATE, 0, 0, 0, amp_t'(-131072)));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 1, '0));
        pending_cmds.push_back(make_cmd(FN_BASIS, 0, 0, 1, '0));
        c = make_cmd(FN_GATE, 0, 0, 0, '0);
        c.m[0] = amp_t'(46341);
        c.m[2] = amp_t'(46341);
        c.m[4] = amp_t'(46341);
        c.m[6] = amp_t'(-46341);
        pending_cmds.push_back(c);
        pending_cmds.push_back(make_cmd(FN_SWAP, 0, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_READ, 0, 0, 1, '0));
        pending_cmds.push_back(make_cmd(FN_CSWAP, 0, 0, 0, '0));
        pending_cmds.push_back(make_cmd(FN_CGATE, 0, 1, 0, '0));

        write_qubits(3);
        run_random(120);
        write_qubits(15);
        run_random(15);
        write_qubits(2);
        run_random(120);
        write_qubits(4);
        run_random(150);
        write_qubits(1);
        run_random(60);
        write_qubits(5);
        run_random(60);
        wait_idle();
        tail_quiet = 1'b1;
        run_random(40);

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
